>>> hdl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler package
// Shared widths, operation codes, the request record that passes from the
// front end to the back end, and the back end state type.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int POS_W  = 48;
  localparam int BYTE_W = 8;
  localparam int PEND_W = 11;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
    logic              sets_end;
    logic [POS_W-1:0]  end_val;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_DONE
  } state_t;

endpackage

>>> hdl/bsr_front.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler front end
// Accepts requests, decodes the operation and works out the end index that a
// request would set, then hands the decoded request to the queue.
// ----------------------------------------------------------------------------
module bsr_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [bsr_pkg::POS_W-1:0] in_stream_index,
  input  logic [bsr_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                      in_is_last_byte,
  input  logic                      q_full,
  input  logic                      clearing,
  output logic                      push,
  output bsr_pkg::cmd_t             push_cmd
);
  import bsr_pkg::*;

  op_t op;

  assign op       = op_t'(in_operation);
  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    push_cmd.op   = op;
    push_cmd.pos  = in_stream_index;
    push_cmd.data = in_data_byte;
    unique case (op)
      OP_STORE: begin
        push_cmd.sets_end = in_is_last_byte;
        push_cmd.end_val  = in_stream_index + POS_W'(1);
      end
      OP_END: begin
        push_cmd.sets_end = 1'b1;
        push_cmd.end_val  = in_stream_index;
      end
      default: begin
        push_cmd.sets_end = 1'b0;
        push_cmd.end_val  = in_stream_index;
      end
    endcase
  end

endmodule

>>> hdl/bsr_queue.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bsr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bsr_pkg::cmd_t    push_cmd,
  output logic             full,
  input  logic             pop,
  output bsr_pkg::q_head_t head
);
  import bsr_pkg::*;

  cmd_t       entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/bsr_back.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler back end
// Holds the window memory and the stream state, carries out one request at a
// time as a read-modify-write of one window entry, and drives the result
// register. A clearing pass over the window follows reset.
// ----------------------------------------------------------------------------
module bsr_back #(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bsr_pkg::q_head_t            head,
  output logic                        pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_read_valid,
  output logic [bsr_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                        out_accepted,
  output logic                        out_stream_ended,
  output logic [bsr_pkg::PEND_W-1:0]  out_pending_count,
  output logic [bsr_pkg::POS_W-1:0]   out_read_point
);
  import bsr_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ENT_W  = BYTE_W + 1;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [POS_W-1:0]  nri_r, nri_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              end_known_r, end_known_nxt;
  logic [POS_W-1:0]  end_index_r, end_index_nxt;

  cmd_t              cmd_r, cmd_nxt;
  logic              in_win_r, in_win_nxt;
  logic              beyond_r, beyond_nxt;
  logic              past_end_r, past_end_nxt;
  logic              ended_r, ended_nxt;
  logic [SLOT_W-1:0] diff_r, diff_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic              res_rvalid_r, res_rvalid_nxt;
  logic [BYTE_W-1:0] res_rbyte_r, res_rbyte_nxt;
  logic              res_acc_r, res_acc_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_rvalid_r, out_rvalid_nxt;
  logic [BYTE_W-1:0] out_rbyte_r, out_rbyte_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic              out_ended_r, out_ended_nxt;
  logic [PEND_W-1:0] out_pend_r, out_pend_nxt;
  logic [POS_W-1:0]  out_rpt_r, out_rpt_nxt;

  logic [ENT_W-1:0]  mem [CAPACITY];
  logic [ENT_W-1:0]  mem_rdata_r;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0]  mem_wdata;

  logic [POS_W:0]         diff;
  logic                   below;
  logic                   in_win;
  logic [SLOT_W:0]        slot_sum;
  logic [SLOT_W-1:0]      slot_calc;
  logic                   old_valid;
  logic [BYTE_W-1:0]      old_byte;
  logic                   out_load;
  logic [CNT_W+PEND_W-1:0] count_ext;

  assign diff      = {1'b0, head.cmd.pos} - {1'b0, nri_r};
  assign below     = diff[POS_W];
  assign in_win    = ~below & (diff[POS_W-1:0] < POS_W'(CAPACITY));
  assign slot_sum  = {1'b0, rslot_r} + {1'b0, diff_r};
  assign slot_calc = (slot_sum >= (SLOT_W+1)'(CAPACITY))
                     ? SLOT_W'(slot_sum - (SLOT_W+1)'(CAPACITY))
                     : slot_sum[SLOT_W-1:0];
  assign old_valid = mem_rdata_r[ENT_W-1];
  assign old_byte  = mem_rdata_r[BYTE_W-1:0];
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign count_ext = {{PEND_W{1'b0}}, count_r};
  assign clearing  = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == SLOT_W'(CAPACITY - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = slot_r;
    mem_raddr      = slot_calc;
    mem_wdata      = '0;
    clr_idx_nxt    = clr_idx_r;
    nri_nxt        = nri_r;
    rslot_nxt      = rslot_r;
    count_nxt      = count_r;
    end_known_nxt  = end_known_r;
    end_index_nxt  = end_index_r;
    cmd_nxt        = cmd_r;
    in_win_nxt     = in_win_r;
    beyond_nxt     = beyond_r;
    past_end_nxt   = past_end_r;
    ended_nxt      = ended_r;
    diff_nxt       = diff_r;
    slot_nxt       = slot_r;
    res_rvalid_nxt = res_rvalid_r;
    res_rbyte_nxt  = res_rbyte_r;
    res_acc_nxt    = res_acc_r;
    out_rvalid_nxt = out_rvalid_r;
    out_rbyte_nxt  = out_rbyte_r;
    out_acc_nxt    = out_acc_r;
    out_ended_nxt  = out_ended_r;
    out_pend_nxt   = out_pend_r;
    out_rpt_nxt    = out_rpt_r;
    out_valid_nxt  = out_load | (out_valid_r & out_stall);
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + SLOT_W'(1);
      end
      ST_IDLE: begin
        if (head.valid) begin
          pop          = 1'b1;
          cmd_nxt      = head.cmd;
          in_win_nxt   = in_win;
          beyond_nxt   = ~below & ~in_win;
          past_end_nxt = end_known_r & (head.cmd.pos >= end_index_r);
          ended_nxt    = end_known_r & (nri_r >= end_index_r);
          diff_nxt     = (head.cmd.op == OP_READ) ? '0 : diff[SLOT_W-1:0];
        end
      end
      ST_FETCH: begin
        mem_re   = 1'b1;
        slot_nxt = slot_calc;
      end
      ST_EXEC: begin
        res_rvalid_nxt = 1'b0;
        res_rbyte_nxt  = '0;
        res_acc_nxt    = 1'b0;
        unique case (cmd_r.op)
          OP_STORE: begin
            if (!beyond_r) begin
              if (in_win_r && !past_end_r) begin
                mem_we      = 1'b1;
                mem_wdata   = {1'b1, cmd_r.data};
                res_acc_nxt = 1'b1;
                if (!old_valid) begin
                  count_nxt = count_r + CNT_W'(1);
                end
              end
              if (cmd_r.sets_end) begin
                end_known_nxt = 1'b1;
                end_index_nxt = cmd_r.end_val;
              end
            end
          end
          OP_END: begin
            if (!beyond_r) begin
              end_known_nxt = 1'b1;
              end_index_nxt = cmd_r.end_val;
            end
          end
          OP_READ: begin
            if (!ended_r && old_valid) begin
              res_rvalid_nxt = 1'b1;
              res_rbyte_nxt  = old_byte;
              mem_we         = 1'b1;
              mem_wdata      = {1'b0, old_byte};
              if (count_r != '0) begin
                count_nxt = count_r - CNT_W'(1);
              end
              nri_nxt   = nri_r + POS_W'(1);
              rslot_nxt = (rslot_r == SLOT_W'(CAPACITY - 1)) ? '0
                          : rslot_r + SLOT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          out_rvalid_nxt = res_rvalid_r;
          out_rbyte_nxt  = res_rbyte_r;
          out_acc_nxt    = res_acc_r;
          out_ended_nxt  = end_known_r & (nri_r >= end_index_r);
          out_pend_nxt   = count_ext[PEND_W-1:0];
          out_rpt_nxt    = nri_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      nri_r       <= '0;
      rslot_r     <= '0;
      count_r     <= '0;
      end_known_r <= 1'b0;
      end_index_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      nri_r       <= nri_nxt;
      rslot_r     <= rslot_nxt;
      count_r     <= count_nxt;
      end_known_r <= end_known_nxt;
      end_index_r <= end_index_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    in_win_r     <= in_win_nxt;
    beyond_r     <= beyond_nxt;
    past_end_r   <= past_end_nxt;
    ended_r      <= ended_nxt;
    diff_r       <= diff_nxt;
    slot_r       <= slot_nxt;
    res_rvalid_r <= res_rvalid_nxt;
    res_rbyte_r  <= res_rbyte_nxt;
    res_acc_r    <= res_acc_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_rbyte_r  <= out_rbyte_nxt;
    out_acc_r    <= out_acc_nxt;
    out_ended_r  <= out_ended_nxt;
    out_pend_r   <= out_pend_nxt;
    out_rpt_r    <= out_rpt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_valid    = out_rvalid_r;
  assign out_read_byte     = out_rbyte_r;
  assign out_accepted      = out_acc_r;
  assign out_stream_ended  = out_ended_r;
  assign out_pending_count = out_pend_r;
  assign out_read_point    = out_rpt_r;

endmodule

>>> hdl/byte_stream_reassembler.sv
// Latency: a request accepted into the queue passes through the back end states
// IDLE, FETCH, EXEC and DONE before it reaches the result register.
// Requests: the back end takes a new request only once the last one has left
// DONE, as each is a read-modify-write of one window entry in its memory.
// Reset: synchronous; afterwards a clearing pass writes every window entry and
// empties the window while in_stall stays high.
// ----------------------------------------------------------------------------
// Byte stream reassembler top level
// Reassembles single out-of-order bytes of a stream in a window of CAPACITY
// bytes and returns the next in-order byte on each read request.
// ----------------------------------------------------------------------------
module byte_stream_reassembler #(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [bsr_pkg::POS_W-1:0]   in_stream_index,
  input  logic [bsr_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_is_last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_read_valid,
  output logic [bsr_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                        out_accepted,
  output logic                        out_stream_ended,
  output logic [bsr_pkg::PEND_W-1:0]  out_pending_count,
  output logic [bsr_pkg::POS_W-1:0]   out_read_point
);
  import bsr_pkg::*;

  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  logic    pop;
  q_head_t head;
  logic    clearing;

  bsr_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_stream_index (in_stream_index),
    .in_data_byte    (in_data_byte),
    .in_is_last_byte (in_is_last_byte),
    .q_full          (q_full),
    .clearing        (clearing),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  bsr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  bsr_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_valid    (out_read_valid),
    .out_read_byte     (out_read_byte),
    .out_accepted      (out_accepted),
    .out_stream_ended  (out_stream_ended),
    .out_pending_count (out_pending_count),
    .out_read_point    (out_read_point)
  );

endmodule

>>> hdl/bsr_checker.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler port checker
// Watches the ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
module bsr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_read_valid,
  input logic [bsr_pkg::BYTE_W-1:0]  out_read_byte,
  input logic                        out_accepted,
  input logic                        out_stream_ended,
  input logic [bsr_pkg::PEND_W-1:0]  out_pending_count,
  input logic [bsr_pkg::POS_W-1:0]   out_read_point
);

  // A result that is held back must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_byte)
      && $stable(out_read_point) && $stable(out_pending_count)
      && $stable(out_read_valid) && $stable(out_accepted)
      && $stable(out_stream_ended))
    else $error("held result changed");

  // Reset starts the clearing pass, so no request is taken and no result shown.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not quiet after reset");

  // A read that delivers nothing reports a zero byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_byte == '0)
    else $error("read byte not zero");

  // A request cannot both deliver a byte and keep a stored one.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_valid && out_accepted))
    else $error("read and store flagged together");

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (.*);

>>> dv/reassembly_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte stream reassembler checker
// Follows every request into the reassembler, works out the reply that the
// window should give for it, and compares each reply taken from the result
// channel field by field, oldest first.
// ----------------------------------------------------------------------------
module reassembly_checker
  import bsr_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [POS_W-1:0]  in_stream_index,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_is_last_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_read_valid,
  input  logic [BYTE_W-1:0] out_read_byte,
  input  logic              out_accepted,
  input  logic              out_stream_ended,
  input  logic [PEND_W-1:0] out_pending_count,
  input  logic [POS_W-1:0]  out_read_point,
  output int                fail_count,
  output int                outstanding,
  output logic [POS_W-1:0]  model_read_point
);

  typedef struct packed {
    logic              rd_valid;
    logic [BYTE_W-1:0] rd_byte;
    logic              kept;
    logic              ended;
    logic [PEND_W-1:0] pending;
    logic [POS_W-1:0]  point;
  } window_reply_t;

  logic [BYTE_W-1:0] bytes_held [CAPACITY];
  bit                slot_full  [CAPACITY];
  logic [POS_W-1:0]  read_at = '0;
  logic [POS_W-1:0]  end_at = '0;
  bit                end_known = 1'b0;
  logic [31:0]       held_count = '0;
  window_reply_t     window_replies [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  initial begin
    outstanding = 0;
    model_read_point = '0;
    foreach (bytes_held[i]) bytes_held[i] = '0;
  end

  function automatic bit in_span(logic [POS_W-1:0] pos);
    return pos >= read_at && (pos - read_at) < POS_W'(CAPACITY);
  endfunction

  function automatic window_reply_t window_apply(op_t op, logic [POS_W-1:0] pos,
                                                 logic [BYTE_W-1:0] data, logic last);
    window_reply_t r;
    bit beyond;
    int slot;
    r = '0;
    beyond = pos >= read_at && !in_span(pos);
    case (op)
      OP_STORE: begin
        if (!beyond) begin
          if (in_span(pos) && !(end_known && pos >= end_at)) begin
            slot = int'(pos % POS_W'(CAPACITY));
            bytes_held[slot] = data;
            if (!slot_full[slot]) begin
              slot_full[slot] = 1'b1;
              held_count++;
            end
            r.kept = 1'b1;
          end
          if (last) begin
            end_known = 1'b1;
            end_at = pos + POS_W'(1);
          end
        end
      end
      OP_END: begin
        if (!beyond) begin
          end_known = 1'b1;
          end_at = pos;
        end
      end
      OP_READ: begin
        if (!(end_known && read_at >= end_at)) begin
          slot = int'(read_at % POS_W'(CAPACITY));
          if (slot_full[slot]) begin
            r.rd_valid = 1'b1;
            r.rd_byte = bytes_held[slot];
            slot_full[slot] = 1'b0;
            if (held_count > 0) held_count--;
            read_at = read_at + POS_W'(1);
          end
        end
      end
      default: ;
    endcase
    r.ended = end_known && read_at >= end_at;
    r.pending = held_count[PEND_W-1:0];
    r.point = read_at;
    return r;
  endfunction

  task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    window_reply_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (window_replies.size() == 0) begin
          $display("%0t: reply with no request awaiting it, expected none, actual %0h",
                   $time, {out_read_valid, out_read_byte, out_accepted, out_stream_ended,
                           out_pending_count, out_read_point});
          mismatches++;
        end else begin
          want = window_replies.pop_front();
          check_field("read_valid", POS_W'(want.rd_valid), POS_W'(out_read_valid));
          check_field("read_byte", POS_W'(want.rd_byte), POS_W'(out_read_byte));
          check_field("accepted", POS_W'(want.kept), POS_W'(out_accepted));
          check_field("stream_ended", POS_W'(want.ended), POS_W'(out_stream_ended));
          check_field("pending_count", POS_W'(want.pending), POS_W'(out_pending_count));
          check_field("read_point", want.point, out_read_point);
        end
      end
      if (in_valid && !in_stall) begin
        window_replies.push_back(window_apply(op_t'(in_operation), in_stream_index,
                                              in_data_byte, in_is_last_byte));
      end
    end
    outstanding <= window_replies.size();
    model_read_point <= read_at;
  end

endmodule

>>> dv/tb_byte_stream_reassembler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte stream reassembler testbench
// Drives a short directed sequence through the window edges, duplicates, end
// marks and empty reads, then shuffled streams with interleaved reads, one
// pass that starts with the block drained, and bursts of stray requests. Both
// channels idle at random; the checker beside the block judges every reply.
// ----------------------------------------------------------------------------
module tb_byte_stream_reassembler;
  import bsr_pkg::*;

  localparam int CAPACITY = 1024;
  localparam int TAIL_CYCLES = 24;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_operation = 2'd0;
  logic [POS_W-1:0]  in_stream_index = '0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_is_last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_read_valid;
  logic [BYTE_W-1:0] out_read_byte;
  logic              out_accepted;
  logic              out_stream_ended;
  logic [PEND_W-1:0] out_pending_count;
  logic [POS_W-1:0]  out_read_point;
  int                fail_count;
  int                outstanding;
  logic [POS_W-1:0]  model_read_point;

  int sent_count = 0;
  bit burst_mode = 1'b0;
  int stall_run = 0;
  int stall_pick;
  bit stall_level = 1'b0;

  typedef int offset_q_t[$];

  byte_stream_reassembler #(.CAPACITY(CAPACITY)) dut (.*);

  reassembly_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        stall_level = 1'b0;
        stall_run = $urandom_range(1, 8);
      end else if (stall_pick < 80) begin
        stall_level = 1'b1;
        stall_run = $urandom_range(1, 3);
      end else if (stall_pick < 95) begin
        stall_level = 1'b1;
        stall_run = $urandom_range(4, 12);
      end else if (stall_pick < 97) begin
        stall_level = 1'b1;
        stall_run = $urandom_range(30, 60);
      end else begin
        stall_level = 1'b0;
        stall_run = $urandom_range(100, 300);
      end
    end else begin
      stall_run--;
    end
    out_stall <= stall_level;
  end

  function automatic logic [POS_W-1:0] any_pos();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[POS_W-1:0];
  endfunction

  function automatic offset_q_t shuffled(int len);
    offset_q_t order;
    int j;
    int tmp;
    for (int i = 0; i < len; i++) order.push_back(i);
    for (int i = len - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    return order;
  endfunction

  task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [BYTE_W-1:0] data,
                              logic last);
    in_valid <= 1'b1;
    in_operation <= op;
    in_stream_index <= pos;
    in_data_byte <= data;
    in_is_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic sender_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (burst_mode || pick < 55) return;
    if (pick < 85) len = $urandom_range(1, 3);
    else if (pick < 97) len = $urandom_range(4, 12);
    else len = $urandom_range(30, 80);
    in_valid <= 1'b0;
    repeat (len) @(posedge clk);
  endtask

  task automatic settle(output logic [POS_W-1:0] base);
    in_valid <= 1'b0;
    @(posedge clk);
    base = model_read_point;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic read_next();
    send_request(OP_READ, any_pos(), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // A stream of len bytes from the current read point, its end set either by
  // an end mark first or by the final byte carrying the last flag.
  task automatic stream_segment(int len, bit spread);
    logic [POS_W-1:0] base;
    offset_q_t order;
    bit by_last;
    int off;
    settle(base);
    burst_mode = ($urandom_range(0, 4) == 0);
    by_last = (len == CAPACITY) || ($urandom_range(0, 2) == 0);
    if (by_last) begin
      send_request(OP_STORE, base + POS_W'(len - 1), 8'($urandom), 1'b1);
    end else begin
      send_request(OP_END, base + POS_W'(len), 8'($urandom), 1'($urandom_range(0, 1)));
    end
    order = shuffled(len);
    foreach (order[k]) begin
      off = order[k];
      sender_gap();
      send_request(OP_STORE, base + POS_W'(off), 8'($urandom),
                   (by_last && off == len - 1) || (spread && $urandom_range(0, 49) == 0));
      if (spread) begin
        if ($urandom_range(0, 3) == 0) begin
          sender_gap();
          read_next();
        end
        if ($urandom_range(0, 9) == 0) begin
          sender_gap();
          send_request(OP_STORE, base + POS_W'(order[$urandom_range(0, k)]), 8'($urandom),
                       1'b0);
        end
        if ($urandom_range(0, 19) == 0) begin
          sender_gap();
          send_request(OP_STORE, base + POS_W'(CAPACITY + $urandom_range(0, 4)),
                       8'($urandom), 1'($urandom_range(0, 1)));
        end
        if (base > POS_W'(8) && $urandom_range(0, 29) == 0) begin
          sender_gap();
          send_request(OP_STORE, base - POS_W'($urandom_range(1, 8)), 8'($urandom),
                       1'b0);
        end
      end
    end
    repeat (len + 2) begin
      sender_gap();
      read_next();
    end
  endtask

  task automatic noise_burst();
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] pos;
    settle(base);
    repeat ($urandom_range(4, 12)) begin
      sender_gap();
      if ($urandom_range(0, 1) == 1) pos = any_pos();
      else pos = base + POS_W'($urandom_range(0, CAPACITY + 16));
      send_request(op_t'(2'($urandom_range(0, 3))), pos, 8'($urandom),
                   1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int target;
    int full_at;
    bit full_done;
    full_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    read_next();
    send_request(OP_NONE, '1, 8'hFF, 1'b1);
    send_request(OP_STORE, POS_W'(0), 8'hFF, 1'b0);
    send_request(OP_STORE, POS_W'(0), 8'h00, 1'b0);
    send_request(OP_STORE, POS_W'(CAPACITY - 1), 8'hA5, 1'b0);
    send_request(OP_STORE, POS_W'(CAPACITY), 8'h3C, 1'b1);
    send_request(OP_END, POS_W'(CAPACITY), 8'h00, 1'b0);
    send_request(OP_STORE, '1, 8'h81, 1'b1);
    send_request(OP_END, '1, 8'hFF, 1'b1);
    read_next();
    send_request(OP_STORE, POS_W'(0), 8'h5A, 1'b0);
    send_request(OP_STORE, POS_W'(0), 8'h5A, 1'b1);
    read_next();
    send_request(OP_STORE, POS_W'(5), 8'h77, 1'b0);
    send_request(OP_END, POS_W'(3), 8'h00, 1'b0);
    send_request(OP_STORE, POS_W'(1), 8'h11, 1'b0);
    send_request(OP_STORE, POS_W'(2), 8'h22, 1'b1);
    repeat (3) read_next();
    send_request(OP_END, POS_W'(0), 8'h00, 1'b0);
    send_request(OP_END, POS_W'(10), 8'h00, 1'b0);
    read_next();

    target = 600;
    full_at = 300;
    while (sent_count < target) begin
      if (!full_done && sent_count >= full_at) begin
        // Let every outstanding request finish before the next stream starts.
        wait_drained();
        stream_segment($urandom_range(41, 120), 1'b0);
        full_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        noise_burst();
      end else if ($urandom_range(0, 7) == 0) begin
        stream_segment($urandom_range(41, 120), 1'b1);
      end else begin
        stream_segment($urandom_range(1, 40), 1'b1);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_byte_stream_reassembler: clean");
    end else begin
      $display("tb_byte_stream_reassembler: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_byte_stream_reassembler: errors");
    $finish;
  end

endmodule
